### rtl/wcov_pkg.sv
package wcov_pkg;

    // Store and window geometry
    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int WINDOW_SIZE = 15;
    localparam int HALF_WIN    = WINDOW_SIZE / 2;
    localparam int KERN_CNT    = WINDOW_SIZE * WINDOW_SIZE;
    localparam int PIX_CNT     = MAX_WIDTH * MAX_HEIGHT;

    localparam int X_AW    = $clog2(MAX_WIDTH);
    localparam int Y_AW    = $clog2(MAX_HEIGHT);
    localparam int PIX_AW  = X_AW + Y_AW;
    localparam int KERN_AW = $clog2(KERN_CNT);
    localparam int WIN_W   = $clog2(WINDOW_SIZE);

    // Field widths
    localparam int COORD_W  = 8;
    localparam int SCOORD_W = COORD_W + 2;   // window position, may go negative
    localparam int SMP_W    = 16;
    localparam int WGT_W    = 16;
    localparam int FRAME_W  = 9;
    localparam int COV_W    = 48;
    localparam int FRAC     = 16;

    // Datapath widths
    localparam int DIFF_W = SMP_W + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int TERM_W = PROD_W + WGT_W;
    localparam int ACC_W  = TERM_W + $clog2(KERN_CNT);
    localparam int PIX_W  = 4 * SMP_W;

    // Stream word layout
    localparam int IN_USER_W  = 2;
    localparam int IN_DATA_W  = 2 * COORD_W + 4 * SMP_W + WGT_W;
    localparam int OUT_DATA_W = COV_W + 2 * COORD_W;
    localparam int POS_X_LO   = 0;
    localparam int POS_Y_LO   = POS_X_LO + COORD_W;
    localparam int SMP1_LO    = POS_Y_LO + COORD_W;
    localparam int WGT_LO     = SMP1_LO + 4 * SMP_W;

    // Frame register reset value
    localparam logic [FRAME_W-1:0] FRAME_RST = FRAME_W'(256);

    // Configuration register indexes
    localparam logic CFG_FRAME_W = 1'b0;
    localparam logic CFG_FRAME_H = 1'b1;

    typedef enum logic [1:0] {
        ACT_WEIGHT = 2'd0,
        ACT_PIXEL  = 2'd1,
        ACT_QUERY  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } t_state;

endpackage

### rtl/wcov_ram.sv
module wcov_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/windowed_weighted_covariance.sv
// Windowed weighted covariance over a 15x15 window.
// Input stream: one word per item. tuser carries the action: load a kernel
// weight, load a pixel (both images, sample and mean), or query the window
// centred on (pos_x, pos_y). Loads write the stores and give no result.
// Output stream: one word per query with the covariance and the centre.
// Config channel: index 0 frame width, 1 frame height, always ready; write
// only while the block is idle.
// Timing: loads can follow back to back while the block is idle. A query
// walks the 225 window terms through one shared read / subtract / multiply /
// multiply / accumulate pipeline at one term per cycle; terms outside the
// frame never enter the pipeline. Input ready returns in the same cycle as
// the result word becomes valid; from the query until then the block takes
// no new item. The pixel RAM has a single read port.
// Stall: the finished result sits in an output register; the block keeps
// taking loads and a new query meanwhile, and a query that completes while
// the previous result is still held waits before handing over.
// Reset: control state and frame registers (256 x 256) reset; pixel and
// weight stores hold whatever they held and must be loaded before use.
module windowed_weighted_covariance (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input word
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // tdata: pos_x, pos_y, sample_one, mean_one, sample_two, mean_two, weight
    input  logic [wcov_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // tuser: action
    input  logic [wcov_pkg::IN_USER_W-1:0]   i_s_axis_tuser,
    // result word
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // tdata: covariance, out_x, out_y
    output logic [wcov_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // configuration
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic                             i_cfg_index,
    input  logic [wcov_pkg::FRAME_W-1:0]     i_cfg_data
);

    // ---------------- input unpack ----------------
    wcov_pkg::t_action                 act;
    logic [wcov_pkg::COORD_W-1:0]      in_x, in_y;
    logic [wcov_pkg::PIX_W-1:0]        in_pix;
    logic [wcov_pkg::WGT_W-1:0]        in_wgt;
    logic                              in_acc;

    assign act    = wcov_pkg::t_action'(i_s_axis_tuser);
    assign in_x   = i_s_axis_tdata[wcov_pkg::POS_X_LO +: wcov_pkg::COORD_W];
    assign in_y   = i_s_axis_tdata[wcov_pkg::POS_Y_LO +: wcov_pkg::COORD_W];
    assign in_pix = i_s_axis_tdata[wcov_pkg::SMP1_LO +: wcov_pkg::PIX_W];
    assign in_wgt = i_s_axis_tdata[wcov_pkg::WGT_LO +: wcov_pkg::WGT_W];
    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;

    // ---------------- configuration ----------------
    logic [wcov_pkg::FRAME_W-1:0] r_frame_w, r_frame_h;
    logic [wcov_pkg::FRAME_W-1:0] fw_eff, fh_eff;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w <= wcov_pkg::FRAME_RST;
            r_frame_h <= wcov_pkg::FRAME_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                wcov_pkg::CFG_FRAME_W: r_frame_w <= i_cfg_data;
                wcov_pkg::CFG_FRAME_H: r_frame_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // frame clipped to the store size
    assign fw_eff = (r_frame_w > wcov_pkg::FRAME_W'(wcov_pkg::MAX_WIDTH)) ?
                    wcov_pkg::FRAME_W'(wcov_pkg::MAX_WIDTH) : r_frame_w;
    assign fh_eff = (r_frame_h > wcov_pkg::FRAME_W'(wcov_pkg::MAX_HEIGHT)) ?
                    wcov_pkg::FRAME_W'(wcov_pkg::MAX_HEIGHT) : r_frame_h;

    // ---------------- control ----------------
    wcov_pkg::t_state r_state, n_state;
    logic [wcov_pkg::KERN_AW-1:0] r_step;
    logic [wcov_pkg::WIN_W-1:0]   r_dx, r_dy;
    logic [wcov_pkg::COORD_W-1:0] r_cx, r_cy;
    logic r_v1, r_v2, r_v3, r_v4;
    logic pipe_busy;
    logic issue, out_load, out_free;

    assign pipe_busy = r_v1 || r_v2 || r_v3 || r_v4;
    assign out_free  = !o_m_axis_tvalid || i_m_axis_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            wcov_pkg::S_IDLE: begin
                if (in_acc && act == wcov_pkg::ACT_QUERY) n_state = wcov_pkg::S_RUN;
            end
            wcov_pkg::S_RUN: begin
                if (r_step == wcov_pkg::KERN_AW'(wcov_pkg::KERN_CNT - 1))
                    n_state = wcov_pkg::S_DRAIN;
            end
            wcov_pkg::S_DRAIN: begin
                if (!pipe_busy) n_state = wcov_pkg::S_DONE;
            end
            wcov_pkg::S_DONE: begin
                if (out_free) n_state = wcov_pkg::S_IDLE;
            end
            default: n_state = wcov_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = 1'b0;
        issue           = 1'b0;
        out_load        = 1'b0;
        case (r_state)
            wcov_pkg::S_IDLE:  o_s_axis_tready = 1'b1;
            wcov_pkg::S_RUN:   issue = 1'b1;
            wcov_pkg::S_DRAIN: ;
            wcov_pkg::S_DONE:  out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wcov_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // window walk: raster order over the kernel
    always_ff @(posedge i_clk) begin
        if (in_acc && act == wcov_pkg::ACT_QUERY) begin
            r_step <= '0;
            r_dx   <= '0;
            r_dy   <= '0;
            r_cx   <= in_x;
            r_cy   <= in_y;
        end else if (issue) begin
            r_step <= r_step + 1'b1;
            if (r_dx == wcov_pkg::WIN_W'(wcov_pkg::WINDOW_SIZE - 1)) begin
                r_dx <= '0;
                r_dy <= r_dy + 1'b1;
            end else begin
                r_dx <= r_dx + 1'b1;
            end
        end
    end

    // ---------------- address generation ----------------
    logic [wcov_pkg::SCOORD_W-1:0] px, py;
    logic                          in_frame;
    logic [wcov_pkg::PIX_AW-1:0]   pix_raddr, pix_waddr;
    logic [wcov_pkg::KERN_AW-1:0]  kern_waddr;
    logic                          pix_we, kern_we;

    assign px = wcov_pkg::SCOORD_W'(r_cx) + wcov_pkg::SCOORD_W'(r_dx)
              - wcov_pkg::SCOORD_W'(wcov_pkg::HALF_WIN);
    assign py = wcov_pkg::SCOORD_W'(r_cy) + wcov_pkg::SCOORD_W'(r_dy)
              - wcov_pkg::SCOORD_W'(wcov_pkg::HALF_WIN);

    // negative positions show up as the top bit set
    assign in_frame = !px[wcov_pkg::SCOORD_W-1] && !py[wcov_pkg::SCOORD_W-1]
                   && (px[wcov_pkg::FRAME_W-1:0] < fw_eff)
                   && (py[wcov_pkg::FRAME_W-1:0] < fh_eff);

    assign pix_raddr = {py[wcov_pkg::Y_AW-1:0], px[wcov_pkg::X_AW-1:0]};
    assign pix_waddr = {in_y[wcov_pkg::Y_AW-1:0], in_x[wcov_pkg::X_AW-1:0]};
    assign pix_we    = in_acc && act == wcov_pkg::ACT_PIXEL
                    && (int'(in_x) < wcov_pkg::MAX_WIDTH)
                    && (int'(in_y) < wcov_pkg::MAX_HEIGHT);

    assign kern_waddr = wcov_pkg::KERN_AW'(int'(in_y) * wcov_pkg::WINDOW_SIZE + int'(in_x));
    assign kern_we    = in_acc && act == wcov_pkg::ACT_WEIGHT
                     && (int'(in_x) < wcov_pkg::WINDOW_SIZE)
                     && (int'(in_y) < wcov_pkg::WINDOW_SIZE);

    // ---------------- stores ----------------
    logic [wcov_pkg::PIX_W-1:0] pix_rdata;
    logic [wcov_pkg::WGT_W-1:0] kern_rdata;

    // pixel word: sample_one, mean_one, sample_two, mean_two from the low end
    wcov_ram #(
        .WIDTH (wcov_pkg::PIX_W),
        .DEPTH (wcov_pkg::PIX_CNT)
    ) u_pix_ram (
        .i_clk   (i_clk),
        .i_we    (pix_we),
        .i_waddr (pix_waddr),
        .i_wdata (in_pix),
        .i_raddr (pix_raddr),
        .o_rdata (pix_rdata)
    );

    wcov_ram #(
        .WIDTH (wcov_pkg::WGT_W),
        .DEPTH (wcov_pkg::KERN_CNT)
    ) u_kern_ram (
        .i_clk   (i_clk),
        .i_we    (kern_we),
        .i_waddr (kern_waddr),
        .i_wdata (in_wgt),
        .i_raddr (r_step),
        .o_rdata (kern_rdata)
    );

    // ---------------- term pipeline ----------------
    // v1: read in flight, v2: differences, v3: d1*d2, v4: weighted term.
    // Out-of-frame terms never enter, so they add nothing.
    logic signed [wcov_pkg::DIFF_W-1:0] r_d1, r_d2;
    logic        [wcov_pkg::WGT_W-1:0]  r_w2, r_w3;
    logic signed [wcov_pkg::PROD_W-1:0] r_p3;
    logic signed [wcov_pkg::TERM_W-1:0] r_t4;
    logic signed [wcov_pkg::ACC_W-1:0]  r_acc;
    logic signed [wcov_pkg::SMP_W-1:0]  s1, m1, s2, m2;

    assign s1 = $signed(pix_rdata[0*wcov_pkg::SMP_W +: wcov_pkg::SMP_W]);
    assign m1 = $signed(pix_rdata[1*wcov_pkg::SMP_W +: wcov_pkg::SMP_W]);
    assign s2 = $signed(pix_rdata[2*wcov_pkg::SMP_W +: wcov_pkg::SMP_W]);
    assign m2 = $signed(pix_rdata[3*wcov_pkg::SMP_W +: wcov_pkg::SMP_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= issue && in_frame;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d1 <= wcov_pkg::DIFF_W'(s1) - wcov_pkg::DIFF_W'(m1);
        r_d2 <= wcov_pkg::DIFF_W'(s2) - wcov_pkg::DIFF_W'(m2);
        r_w2 <= kern_rdata;
        r_p3 <= r_d1 * r_d2;
        r_w3 <= r_w2;
        r_t4 <= r_p3 * $signed({1'b0, r_w3});
    end

    // 225 terms below 2^48 each fit ACC_W (58 bits) with headroom
    always_ff @(posedge i_clk) begin
        if (in_acc && act == wcov_pkg::ACT_QUERY) begin
            r_acc <= '0;
        end else if (r_v4) begin
            r_acc <= r_acc + wcov_pkg::ACC_W'(r_t4);
        end
    end

    // ---------------- output register ----------------
    // Floor shift by 16 leaves 42 bits, sign-extended to the 48-bit covariance.
    logic signed [wcov_pkg::COV_W-1:0] cov;
    logic                              r_out_valid;
    logic [wcov_pkg::OUT_DATA_W-1:0]   r_out_data;

    assign cov = wcov_pkg::COV_W'($signed(r_acc[wcov_pkg::ACC_W-1:wcov_pkg::FRAC]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {r_cy, r_cx, cov};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // ---------------- assertions ----------------
    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !pipe_busy)
        else $error("input taken while term pipeline busy");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wcov_pkg::S_RUN) |-> (int'(r_step) < wcov_pkg::KERN_CNT))
        else $error("window step past kernel end");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_m_axis_tvalid && r_state == wcov_pkg::S_IDLE))
        else $error("result hand-off did not complete");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !out_load)
        else $error("held result overwritten");

endmodule
